/* rtl/nip_pkg.sv */
`default_nettype none

package nip_pkg;

  // record tags
  localparam logic [4:0] TAG_DISCOVERY_ID   = 5'd0;
  localparam logic [4:0] TAG_DATA_EXCH_MODE = 5'd6;
  localparam logic [4:0] TAG_ATQA           = 5'd9;
  localparam logic [4:0] TAG_NFCID1         = 5'd10;
  localparam logic [4:0] TAG_SEL_RES        = 5'd11;
  localparam logic [4:0] TAG_NFCID0         = 5'd12;
  localparam logic [4:0] TAG_POLL_B_FSC     = 5'd13;
  localparam logic [4:0] TAG_ATS_FSC        = 5'd14;
  localparam logic [4:0] TAG_HIST_BYTE      = 5'd15;
  localparam logic [4:0] TAG_STATUS         = 5'd16;

  // header byte positions and position limits
  localparam logic [8:0] POS_RF_INTF    = 9'd1;
  localparam logic [8:0] POS_RF_MODE    = 9'd3;
  localparam logic [8:0] POS_HDR_END    = 9'd6;
  localparam logic [8:0] POS_TECH_LEN   = 9'd6;
  localparam logic [8:0] POS_LONG       = 9'd255;
  localparam logic [8:0] POS_SAT        = 9'd511;

  // mode and interface codes
  localparam logic [7:0] MODE_PASSIVE_POLL_A = 8'h00;
  localparam logic [7:0] MODE_PASSIVE_POLL_B = 8'h01;
  localparam logic [7:0] MODE_ACTIVE_POLL_A  = 8'h03;
  localparam logic [7:0] INTF_ISO_DEP        = 8'h02;

  // ATS format byte bits
  localparam logic [7:0] T0_TA   = 8'h10;
  localparam logic [7:0] T0_TB   = 8'h20;
  localparam logic [7:0] T0_TC   = 8'h40;
  localparam logic [7:0] T0_FSCI = 8'h0f;

  localparam logic [7:0] SENSB_MIN        = 8'd11;
  localparam logic [7:0] MAX_NFCID1_BYTES = 8'd10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef struct packed {
    logic [4:0] tag;
    logic [3:0] index;
    logic [8:0] value;
  } nip_field_t;

  // one queue entry: an optional field record and an optional status record
  typedef struct packed {
    logic       has_field;
    nip_field_t field;
    logic       has_status;
    logic       packet_ok;
    logic       mode_param_ok;
    logic       activation_ok;
  } nip_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } nip_q_stat_t;

  localparam logic [8:0] FSC_BYTES [9] = '{
    9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd64, 9'd96, 9'd128, 9'd256
  };

  function automatic logic [8:0] fsc_of(input logic [3:0] code);
    logic [8:0] r;
    if (code > 4'd8) begin
      r = FSC_BYTES[8];
    end else begin
      r = FSC_BYTES[code];
    end
    return r;
  endfunction

  function automatic logic is_poll_a(input logic [7:0] mode);
    return (mode == MODE_PASSIVE_POLL_A) || (mode == MODE_ACTIVE_POLL_A);
  endfunction

  function automatic logic [1:0] ats_skip(input logic [7:0] t0);
    return {1'b0, |(t0 & T0_TA)} + {1'b0, |(t0 & T0_TB)} + {1'b0, |(t0 & T0_TC)};
  endfunction

endpackage

`default_nettype wire

/* rtl/nip_chan_if.sv */
`default_nettype none

interface nip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nip_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] tag;
  logic [3:0] index;
  logic [8:0] value;
  logic       packet_ok;
  logic       mode_param_ok;
  logic       activation_ok;
  logic       last;

  modport source (output valid, output tag, output index, output value,
                  output packet_ok, output mode_param_ok, output activation_ok,
                  output last, input ready);
  modport sink (input valid, input tag, input index, input value,
                input packet_ok, input mode_param_ok, input activation_ok,
                input last, output ready);
endinterface

`default_nettype wire

/* rtl/nip_front.sv */
`default_nettype none

module nip_front (
  input  wire                  clk,
  input  wire                  rst_n,
  nip_in_if.sink               in_bus,
  input  nip_pkg::nip_q_stat_t q_stat,
  output logic                 push,
  output nip_pkg::nip_entry_t  entry
);

  logic [8:0] pos_r, pos_nxt;
  logic [7:0] n_r, n_nxt;
  logic [7:0] m_r, m_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic [7:0] intf_r, intf_nxt;
  logic [7:0] n1_r, n1_nxt;
  logic [7:0] sel_r, sel_nxt;
  logic [7:0] ats_r, ats_nxt;
  logic [7:0] t0_r, t0_nxt;
  logic       sensb_ok_r, sensb_ok_nxt;

  logic       accept;
  logic [7:0] b;
  logic [9:0] p10, n10, m10;
  logic [9:0] tech_end, trail_end, act_len_pos, act_end, trail_off, a10;
  logic [7:0] o, a;
  logic [8:0] o9, n1_9;
  logic [1:0] skip_cur, skip_nxt;
  logic [7:0] hist_idx;
  logic [9:0] len10;
  logic [8:0] n1_need, sel_need;
  logic       pok, mok, aok;

  assign accept = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !q_stat.full;
  assign b = in_bus.data_byte;

  assign p10         = {1'b0, pos_r};
  assign n10         = {2'b0, n_r};
  assign m10         = {2'b0, m_r};
  assign tech_end    = 10'd7 + n10;
  assign trail_end   = 10'd9 + n10;
  assign act_len_pos = 10'd10 + n10;
  assign act_end     = 10'd11 + n10 + m10;
  assign trail_off   = p10 - 10'd7 - n10;
  assign a10         = p10 - 10'd11 - n10;
  assign o           = pos_r[7:0] - 8'd7;
  assign a           = a10[7:0];
  assign o9          = {1'b0, o};
  assign n1_9        = {1'b0, n1_r};
  assign skip_cur    = nip_pkg::ats_skip(t0_r);
  assign hist_idx    = a - 8'd2 - {6'b0, skip_cur};

  // byte decode and state update
  always_comb begin
    entry         = '0;
    n_nxt         = n_r;
    m_nxt         = m_r;
    mode_nxt      = mode_r;
    intf_nxt      = intf_r;
    n1_nxt        = n1_r;
    sel_nxt       = sel_r;
    ats_nxt       = ats_r;
    t0_nxt        = t0_r;
    sensb_ok_nxt  = sensb_ok_r;
    if (pos_r < nip_pkg::POS_LONG) begin
      if (pos_r < nip_pkg::POS_HDR_END) begin
        entry.has_field   = 1'b1;
        entry.field.tag   = nip_pkg::TAG_DISCOVERY_ID + pos_r[4:0];
        entry.field.value = {1'b0, b};
        if (pos_r == nip_pkg::POS_RF_INTF) intf_nxt = b;
        if (pos_r == nip_pkg::POS_RF_MODE) mode_nxt = b;
      end else if (pos_r == nip_pkg::POS_TECH_LEN) begin
        n_nxt = b;
      end else if (p10 < tech_end) begin
        if (nip_pkg::is_poll_a(mode_r)) begin
          if (o < 8'd2) begin
            entry.has_field   = 1'b1;
            entry.field.tag   = nip_pkg::TAG_ATQA;
            entry.field.index = o[3:0];
            entry.field.value = {1'b0, b};
          end else if (o == 8'd2) begin
            n1_nxt = b;
          end else if (n1_r <= nip_pkg::MAX_NFCID1_BYTES) begin
            if (o9 < 9'd3 + n1_9) begin
              entry.has_field   = 1'b1;
              entry.field.tag   = nip_pkg::TAG_NFCID1;
              entry.field.index = 4'(o - 8'd3);
              entry.field.value = {1'b0, b};
            end else if (o9 == 9'd3 + n1_9) begin
              sel_nxt = b;
            end else if (o9 == 9'd4 + n1_9 && sel_r != 8'd0) begin
              entry.has_field   = 1'b1;
              entry.field.tag   = nip_pkg::TAG_SEL_RES;
              entry.field.value = {1'b0, b};
            end
          end
        end else if (mode_r == nip_pkg::MODE_PASSIVE_POLL_B) begin
          if (o == 8'd0) begin
            if (b >= nip_pkg::SENSB_MIN) sensb_ok_nxt = 1'b1;
          end else if (o <= 8'd4) begin
            entry.has_field   = 1'b1;
            entry.field.tag   = nip_pkg::TAG_NFCID0;
            entry.field.index = 4'(o - 8'd1);
            entry.field.value = {1'b0, b};
          end else if (o == 8'd10) begin
            entry.has_field   = 1'b1;
            entry.field.tag   = nip_pkg::TAG_POLL_B_FSC;
            entry.field.value = nip_pkg::fsc_of(b[7:4]);
          end
        end
      end else if (p10 <= trail_end) begin
        entry.has_field   = 1'b1;
        entry.field.tag   = nip_pkg::TAG_DATA_EXCH_MODE + trail_off[4:0];
        entry.field.value = {1'b0, b};
      end else if (p10 == act_len_pos) begin
        m_nxt = b;
      end else if (p10 < act_end) begin
        if (intf_r == nip_pkg::INTF_ISO_DEP && nip_pkg::is_poll_a(mode_r)) begin
          if (a == 8'd0) begin
            ats_nxt = b;
          end else if (a <= ats_r) begin
            if (a == 8'd1) begin
              t0_nxt            = b;
              entry.has_field   = 1'b1;
              entry.field.tag   = nip_pkg::TAG_ATS_FSC;
              entry.field.value = nip_pkg::fsc_of(4'(b & nip_pkg::T0_FSCI));
            end else if ({1'b0, a} >= 9'd2 + {7'b0, skip_cur}) begin
              entry.has_field   = 1'b1;
              entry.field.tag   = nip_pkg::TAG_HIST_BYTE;
              entry.field.index = hist_idx[3:0];
              entry.field.value = {1'b0, b};
            end
          end
        end
      end
    end
    pos_nxt = (pos_r == nip_pkg::POS_SAT) ? pos_r : pos_r + 9'd1;

    entry.has_status    = in_bus.last_byte;
    entry.packet_ok     = pok;
    entry.mode_param_ok = mok;
    entry.activation_ok = aok;
  end

  // status flags from the state as it stands after this byte
  assign len10    = {1'b0, pos_nxt};
  assign skip_nxt = nip_pkg::ats_skip(t0_nxt);
  assign n1_need  = 9'd4 + {1'b0, n1_nxt};
  assign sel_need = n1_need + {1'b0, sel_nxt};

  always_comb begin
    pok = (pos_nxt <= nip_pkg::POS_LONG) && (n_nxt != 8'd0)
        && (len10 >= 10'd11 + {2'b0, n_nxt} + {2'b0, m_nxt});
    mok = 1'b0;
    aok = 1'b0;
    if (pok && nip_pkg::is_poll_a(mode_nxt)) begin
      mok = (n_nxt >= 8'd4) && (n1_nxt <= nip_pkg::MAX_NFCID1_BYTES)
          && ({1'b0, n_nxt} >= n1_need) && ({1'b0, n_nxt} >= sel_need);
    end else if (pok && mode_nxt == nip_pkg::MODE_PASSIVE_POLL_B) begin
      mok = (n_nxt >= nip_pkg::SENSB_MIN) && sensb_ok_nxt;
    end
    if (pok && m_nxt != 8'd0 && intf_nxt == nip_pkg::INTF_ISO_DEP
        && nip_pkg::is_poll_a(mode_nxt)) begin
      aok = (ats_nxt >= 8'd1) && ({1'b0, m_nxt} >= {1'b0, ats_nxt} + 9'd1)
          && ({7'b0, skip_nxt} + 9'd1 <= {1'b0, ats_nxt});
    end
  end

  assign push = accept && (entry.has_field || entry.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_bus.last_byte)) begin
      pos_r      <= '0;
      n_r        <= '0;
      m_r        <= '0;
      mode_r     <= '0;
      intf_r     <= '0;
      n1_r       <= '0;
      sel_r      <= '0;
      ats_r      <= '0;
      t0_r       <= '0;
      sensb_ok_r <= 1'b0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      n_r        <= n_nxt;
      m_r        <= m_nxt;
      mode_r     <= mode_nxt;
      intf_r     <= intf_nxt;
      n1_r       <= n1_nxt;
      sel_r      <= sel_nxt;
      ats_r      <= ats_nxt;
      t0_r       <= t0_nxt;
      sensb_ok_r <= sensb_ok_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_bus.last_byte |=> pos_r == 9'd0)
    else $error("byte position not cleared after final byte");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("entry written into full queue");
`endif

endmodule

`default_nettype wire

/* rtl/nip_queue.sv */
`default_nettype none

module nip_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  nip_pkg::nip_entry_t   wr_entry,
  input  wire                   pop,
  output nip_pkg::nip_entry_t   head,
  output nip_pkg::nip_q_stat_t  q_stat
);

  nip_pkg::nip_entry_t             slots_r [nip_pkg::QUEUE_DEPTH];
  logic [nip_pkg::QUEUE_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [nip_pkg::QUEUE_CW-1:0]    count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == nip_pkg::QUEUE_CW'(nip_pkg::QUEUE_DEPTH));
  assign head         = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nip_pkg::QUEUE_CW'(nip_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/nip_back.sv */
`default_nettype none

module nip_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  nip_pkg::nip_entry_t   head,
  input  nip_pkg::nip_q_stat_t  q_stat,
  output logic                  pop,
  nip_out_if.source             out_bus
);

  logic                 out_valid_r;
  nip_pkg::nip_field_t  rec_r, rec_nxt;
  logic                 pok_r, mok_r, aok_r, last_r;
  logic                 pok_nxt, mok_nxt, aok_nxt, last_nxt;
  logic                 phase_r, phase_nxt;
  logic                 load;
  logic                 emit_field;

  assign load       = !out_valid_r || out_bus.ready;
  assign emit_field = head.has_field && !phase_r;

  always_comb begin
    pop       = 1'b0;
    phase_nxt = phase_r;
    rec_nxt   = head.field;
    pok_nxt   = 1'b0;
    mok_nxt   = 1'b0;
    aok_nxt   = 1'b0;
    last_nxt  = 1'b0;
    if (load && !q_stat.empty) begin
      if (emit_field) begin
        // status record of the same entry follows next
        if (head.has_status) begin
          phase_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        rec_nxt.tag   = nip_pkg::TAG_STATUS;
        rec_nxt.index = '0;
        rec_nxt.value = '0;
        pok_nxt       = head.packet_ok;
        mok_nxt       = head.mode_param_ok;
        aok_nxt       = head.activation_ok;
        last_nxt      = 1'b1;
        pop           = 1'b1;
        phase_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) out_valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      rec_r  <= rec_nxt;
      pok_r  <= pok_nxt;
      mok_r  <= mok_nxt;
      aok_r  <= aok_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.tag           = rec_r.tag;
  assign out_bus.index         = rec_r.index;
  assign out_bus.value         = rec_r.value;
  assign out_bus.packet_ok     = pok_r;
  assign out_bus.mode_param_ok = mok_r;
  assign out_bus.activation_ok = aok_r;
  assign out_bus.last          = last_r;

`ifndef ASSERT_OFF
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_stat.empty && head.has_status)
    else $error("split entry lost from queue head");
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> rec_r.tag == nip_pkg::TAG_STATUS && rec_r.value == 9'd0)
    else $error("final record is not a status record");
`endif

endmodule

`default_nettype wire

/* rtl/nci_intf_activated_ntf_parser.sv */
// rf interface activated notification parser
//
// in_bus carries the notification payload, one byte per transfer, with
// last_byte set on the final byte. out_bus carries tagged field records:
// header and data exchange fields, nfc-a / nfc-b poll fields and iso-dep ats fields, and after
// the final byte one status record (last set) with the packet, mode parameter
// and activation validity flags. field records go out before validity is
// known; the consumer drops them when the status flags fail.
//
// throughput: one byte per cycle in, one record per cycle out, while neither
// in_bus.ready nor out_bus.ready is held low. a byte gives at most one field
// record; the final byte may give a field record and the status record.
// a byte's transfer writes the decoded entry into a 4-entry queue, and the
// output register loads from the queue head once it is free.
// in_bus.ready drops only while the queue is full: when the receiver holds
// out_bus.ready low, or when two-record final bytes come faster than the
// output side drains them.
// reset (rst_n low, synchronous) empties queue and output register and
// clears the parse state; the parse state also clears after each final byte.
`default_nettype none

module nci_intf_activated_ntf_parser (
  input  wire         clk,
  input  wire         rst_n,
  nip_in_if.sink      in_bus,
  nip_out_if.source   out_bus
);

  // front to queue
  logic                  push;
  nip_pkg::nip_entry_t   wr_entry;

  // queue to back
  logic                  pop;
  nip_pkg::nip_entry_t   head;
  nip_pkg::nip_q_stat_t  q_stat;

  // byte decode and parse state
  nip_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_stat (q_stat),
    .push   (push),
    .entry  (wr_entry)
  );

  // decouples decode from the output side
  nip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // splits entries into records, holds the output register
  nip_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

/* bench/nip_tb_pkg.sv */
`timescale 1ns / 1ps

package nip_tb_pkg;

  // one record as seen on out_bus
  typedef struct packed {
    logic [4:0] tag;
    logic [3:0] index;
    logic [8:0] value;
    logic       packet_ok;
    logic       mode_param_ok;
    logic       activation_ok;
    logic       last;
  } nip_rec_t;

  class ntf_record_board;
    nip_rec_t pending_records[$];
    int errors = 0;
    int checked = 0;
    int packets = 0;
    int bytes_in = 0;
    int pkt_ok_count = 0;
    int mode_ok_count = 0;
    int act_ok_count = 0;

    // parse state, kept in step with the block
    logic [8:0] pos = '0;
    logic [7:0] tech_len = '0;
    logic [7:0] act_len = '0;
    logic [7:0] mode = '0;
    logic [7:0] intf = '0;
    logic [7:0] id1_len = '0;
    logic [7:0] sel_len = '0;
    logic [7:0] ats_len = '0;
    logic [7:0] t0 = '0;
    logic       sensb_ok = 1'b0;

    function void clear_parse();
      pos = '0;
      tech_len = '0;
      act_len = '0;
      mode = '0;
      intf = '0;
      id1_len = '0;
      sel_len = '0;
      ats_len = '0;
      t0 = '0;
      sensb_ok = 1'b0;
    endfunction

    function bit poll_a();
      return mode == nip_pkg::MODE_PASSIVE_POLL_A || mode == nip_pkg::MODE_ACTIVE_POLL_A;
    endfunction

    // interface bytes announced by t0 ahead of the historical bytes
    function int t0_skip();
      return int'((t0 & nip_pkg::T0_TA) != 0) + int'((t0 & nip_pkg::T0_TB) != 0)
             + int'((t0 & nip_pkg::T0_TC) != 0);
    endfunction

    function logic [8:0] fsc_size(int code);
      case (code)
        0: return 9'd16;
        1: return 9'd24;
        2: return 9'd32;
        3: return 9'd40;
        4: return 9'd48;
        5: return 9'd64;
        6: return 9'd96;
        7: return 9'd128;
        default: return 9'd256;
      endcase
    endfunction

    function void emit(logic [4:0] tag, int idx, int val);
      nip_rec_t r;
      r = '0;
      r.tag = tag;
      r.index = 4'(idx);
      r.value = 9'(val);
      pending_records.push_back(r);
    endfunction

    function void tech_byte(int o, logic [7:0] b);
      int n1;
      n1 = id1_len;
      if (poll_a()) begin
        if (o < 2) emit(nip_pkg::TAG_ATQA, o, b);
        else if (o == 2) id1_len = b;
        else if (n1 <= nip_pkg::MAX_NFCID1_BYTES) begin
          if (o < 3 + n1) emit(nip_pkg::TAG_NFCID1, o - 3, b);
          else if (o == 3 + n1) sel_len = b;
          else if (o == 4 + n1 && sel_len != 0) emit(nip_pkg::TAG_SEL_RES, 0, b);
        end
      end else if (mode == nip_pkg::MODE_PASSIVE_POLL_B) begin
        if (o == 0) begin
          if (b >= nip_pkg::SENSB_MIN) sensb_ok = 1'b1;
        end else if (o <= 4) emit(nip_pkg::TAG_NFCID0, o - 1, b);
        else if (o == 10) emit(nip_pkg::TAG_POLL_B_FSC, 0, fsc_size(b >> 4));
      end
    endfunction

    function void act_byte(int a, logic [7:0] b);
      int skip;
      skip = t0_skip();
      if (intf != nip_pkg::INTF_ISO_DEP || !poll_a()) return;
      if (a == 0) ats_len = b;
      else if (a <= ats_len) begin
        if (a == 1) begin
          t0 = b;
          emit(nip_pkg::TAG_ATS_FSC, 0, fsc_size(b & nip_pkg::T0_FSCI));
        end else if (a >= 2 + skip) emit(nip_pkg::TAG_HIST_BYTE, (a - 2 - skip) % 16, b);
      end
    endfunction

    function void decode(int p, logic [7:0] b);
      int n;
      int m;
      n = tech_len;
      m = act_len;
      if (p < nip_pkg::POS_HDR_END) begin
        if (p == nip_pkg::POS_RF_INTF) intf = b;
        if (p == nip_pkg::POS_RF_MODE) mode = b;
        emit(nip_pkg::TAG_DISCOVERY_ID + 5'(p), 0, b);
      end else if (p == nip_pkg::POS_TECH_LEN) tech_len = b;
      else if (p < 7 + n) tech_byte(p - 7, b);
      else if (p <= 9 + n) emit(nip_pkg::TAG_DATA_EXCH_MODE + 5'(p - 7 - n), 0, b);
      else if (p == 10 + n) act_len = b;
      else if (p < 11 + n + m) act_byte(p - 11 - n, b);
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      int len;
      int n;
      int m;
      int n1;
      bit pkt_ok;
      bit mode_ok;
      bit act_ok;
      nip_rec_t st;
      bytes_in++;
      if (pos < nip_pkg::POS_LONG) decode(int'(pos), b);
      if (pos < nip_pkg::POS_SAT) pos = pos + 9'd1;
      if (fin) begin
        len = pos;
        n = tech_len;
        m = act_len;
        n1 = id1_len;
        pkt_ok = len <= int'(nip_pkg::POS_LONG) && n != 0 && len >= 11 + n + m;
        mode_ok = 1'b0;
        act_ok = 1'b0;
        if (pkt_ok && poll_a())
          mode_ok = n >= 4 && n1 <= int'(nip_pkg::MAX_NFCID1_BYTES) && n >= n1 + 4
                    && n >= n1 + 4 + int'(sel_len);
        else if (pkt_ok && mode == nip_pkg::MODE_PASSIVE_POLL_B)
          mode_ok = n >= int'(nip_pkg::SENSB_MIN) && sensb_ok;
        if (pkt_ok && m != 0 && intf == nip_pkg::INTF_ISO_DEP && poll_a())
          act_ok = ats_len >= 1 && m >= int'(ats_len) + 1 && 1 + t0_skip() <= int'(ats_len);
        st = '0;
        st.tag = nip_pkg::TAG_STATUS;
        st.packet_ok = pkt_ok;
        st.mode_param_ok = mode_ok;
        st.activation_ok = act_ok;
        st.last = 1'b1;
        pending_records.push_back(st);
        packets++;
        pkt_ok_count += pkt_ok;
        mode_ok_count += mode_ok;
        act_ok_count += act_ok;
        clear_parse();
      end
    endfunction

    function string rec_text(nip_rec_t r);
      return $sformatf("tag=%0d index=%0d value=%0d ok=%b/%b/%b last=%b", r.tag, r.index,
                       r.value, r.packet_ok, r.mode_param_ok, r.activation_ok, r.last);
    endfunction

    function void check_record(nip_rec_t got);
      nip_rec_t want;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: mismatch, expected no record, actual %s", $time, rec_text(got));
        return;
      end
      want = pending_records.pop_front();
      checked++;
      if (got.tag !== want.tag || got.index !== want.index || got.value !== want.value
          || got.packet_ok !== want.packet_ok || got.mode_param_ok !== want.mode_param_ok
          || got.activation_ok !== want.activation_ok || got.last !== want.last) begin
        errors++;
        $display("%0t: mismatch, expected %s, actual %s", $time, rec_text(want),
                 rec_text(got));
      end
    endfunction
  endclass

endpackage

/* bench/tb_nci_intf_activated_ntf_parser.sv */
`timescale 1ns / 1ps

module tb_nci_intf_activated_ntf_parser;

  localparam int BYTE_TARGET = 900;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_e;

  logic clk;
  logic rst_n;
  int   cycles;

  nip_in_if  in_bus ();
  nip_out_if out_bus ();

  nci_intf_activated_ntf_parser u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  nip_tb_pkg::ntf_record_board board = new;

  // packet under construction and its technology / activation sections
  logic [7:0] pkt[$];
  logic [7:0] tech_q[$];
  logic [7:0] act_q[$];
  int         burst_left;
  int         long_pkts;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: no completion after %0d cycles", $time, cycles);
    $display("nci_intf_activated_ntf_parser verification failed");
    $finish;
  end

  // receiver: phases of always ready, coin-flip ready, and a choke pattern,
  // repeating with rx_tick, that holds ready low so the internal queue fills up
  initial begin
    rx_mode_e rx_mode;
    int       rx_left;
    int       rx_tick;
    out_bus.ready <= 1'b0;
    rx_mode = RX_OPEN;
    rx_left = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 120);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_RANDOM: out_bus.ready <= 1'($urandom_range(0, 1));
        default:   out_bus.ready <= (rx_tick % 9) >= 6;
      endcase
    end
  end

  // every record transfer goes to the board
  always @(posedge clk) begin
    nip_tb_pkg::nip_rec_t got;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.tag           = out_bus.tag;
      got.index         = out_bus.index;
      got.value         = out_bus.value;
      got.packet_ok     = out_bus.packet_ok;
      got.mode_param_ok = out_bus.mode_param_ok;
      got.activation_ok = out_bus.activation_ok;
      got.last          = out_bus.last;
      board.check_record(got);
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // one byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long stretch with no idle cycle
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= fin;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    board.note_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // hold the sender off until every expected record has come out
  task automatic wait_for_records();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (board.pending_records.size() != 0) @(negedge clk);
  endtask

  // atqa, nfcid1 length and bytes, sel_res length and sel_res
  function automatic void fill_tech_poll_a();
    int n1;
    int sel;
    tech_q.delete();
    tech_q.push_back(rnd8());
    tech_q.push_back(rnd8());
    case ($urandom_range(0, 9))
      0:       n1 = $urandom_range(int'(nip_pkg::MAX_NFCID1_BYTES) + 1, 255);  // oversized
      1, 2:    n1 = $urandom_range(0, int'(nip_pkg::MAX_NFCID1_BYTES));
      3, 4, 5: n1 = 4;
      6, 7:    n1 = 7;
      default: n1 = int'(nip_pkg::MAX_NFCID1_BYTES);
    endcase
    tech_q.push_back(8'(n1));
    repeat ((n1 > int'(nip_pkg::MAX_NFCID1_BYTES)) ? $urandom_range(0, 6) : n1)
      tech_q.push_back(rnd8());
    sel = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 255) : $urandom_range(0, 1);
    tech_q.push_back(8'(sel));
    if (sel != 0) tech_q.push_back(rnd8());
  endfunction

  // atqb length first, then nfcid0, app data and protocol info
  function automatic void fill_tech_poll_b();
    int n;
    tech_q.delete();
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, int'(nip_pkg::SENSB_MIN) - 1)
                                    : $urandom_range(int'(nip_pkg::SENSB_MIN), 14);
    tech_q.push_back(($urandom_range(0, 4) == 0)
                     ? 8'($urandom_range(0, int'(nip_pkg::SENSB_MIN) - 1))
                     : 8'($urandom_range(int'(nip_pkg::SENSB_MIN), 255)));
    repeat (n - 1) tech_q.push_back(rnd8());
  endfunction

  // ats: length, t0, the interface bytes t0 announces, historical bytes
  function automatic void fill_act_iso();
    int         skip;
    int         hist;
    int         ats;
    logic [7:0] t0;
    act_q.delete();
    t0 = rnd8();
    skip = int'((t0 & nip_pkg::T0_TA) != 0) + int'((t0 & nip_pkg::T0_TB) != 0)
           + int'((t0 & nip_pkg::T0_TC) != 0);
    // long historical runs wrap the 4-bit index
    hist = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    ats = 1 + skip + hist;
    if ($urandom_range(0, 7) == 0) ats = $urandom_range(0, ats + 2);
    act_q.push_back(8'(ats));
    act_q.push_back(t0);
    repeat (skip + hist) act_q.push_back(rnd8());
  endfunction

  function automatic void fill_act_random();
    act_q.delete();
    repeat ($urandom_range(0, 5)) act_q.push_back(rnd8());
  endfunction

  // header, n, tech params, three exchange bytes, m, activation params;
  // sometimes wrong lengths, trailing bytes or a cut-off packet
  function automatic void assemble(logic [7:0] mode, logic [7:0] intf);
    int n;
    int m;
    int cut;
    n = tech_q.size();
    m = act_q.size();
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n + 3);
    if ($urandom_range(0, 9) == 0) m = $urandom_range(0, m + 3);
    pkt.delete();
    pkt.push_back(rnd8());
    pkt.push_back(intf);
    pkt.push_back(rnd8());
    pkt.push_back(mode);
    pkt.push_back(rnd8());
    pkt.push_back(rnd8());
    pkt.push_back(8'(n));
    foreach (tech_q[i]) pkt.push_back(tech_q[i]);
    repeat (3) pkt.push_back(rnd8());
    pkt.push_back(8'(m));
    foreach (act_q[i]) pkt.push_back(act_q[i]);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) pkt.push_back(rnd8());
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endfunction

  function automatic void build_random_packet();
    int         kind;
    logic [7:0] intf;
    kind = $urandom_range(0, 99);
    intf = ($urandom_range(0, 4) == 0) ? rnd8() : nip_pkg::INTF_ISO_DEP;
    if (kind < 55) begin
      fill_tech_poll_a();
      if (intf == nip_pkg::INTF_ISO_DEP) fill_act_iso();
      else fill_act_random();
      assemble((kind < 30) ? nip_pkg::MODE_PASSIVE_POLL_A : nip_pkg::MODE_ACTIVE_POLL_A,
               intf);
    end else if (kind < 80) begin
      fill_tech_poll_b();
      fill_act_random();
      assemble(nip_pkg::MODE_PASSIVE_POLL_B, intf);
    end else if (kind < 90) begin
      // unhandled mode: random technology and activation bytes
      tech_q.delete();
      repeat ($urandom_range(0, 12)) tech_q.push_back(rnd8());
      fill_act_random();
      assemble(8'($urandom_range(4, 255)), intf);
    end else begin
      // raw noise, often too short for the header
      pkt.delete();
      repeat ($urandom_range(1, 24)) pkt.push_back(rnd8());
    end
  endfunction

  // well-formed start, padded with trailing bytes to an exact length
  function automatic void build_long_packet(int len);
    fill_tech_poll_a();
    fill_act_iso();
    assemble(nip_pkg::MODE_PASSIVE_POLL_A, nip_pkg::INTF_ISO_DEP);
    while (pkt.size() < len) pkt.push_back(rnd8());
  endfunction

  initial begin
    int sent_bytes;
    int pkt_count;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last_byte <= 1'b0;
    burst_left   = 0;
    long_pkts    = 0;
    sent_bytes   = 0;
    pkt_count    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // a lone final byte: the discovery id record, then a status record with
    // every flag clear
    pkt = {8'hff};
    send_packet();
    // passive poll a over iso-dep, 4-byte nfcid1 and sel_res, ats with ta, tb
    // and tc present and an fsci above 8; lengths exactly consistent
    pkt = {8'h00, nip_pkg::INTF_ISO_DEP, 8'h04, nip_pkg::MODE_PASSIVE_POLL_A, 8'hff, 8'h00,
           8'd9, 8'h44, 8'h00, 8'd4, 8'h08, 8'h12, 8'h34, 8'h56, 8'd1, 8'h20,
           8'h00, 8'h00, 8'h00,
           8'd6, 8'd5, 8'h7f, 8'h11, 8'h22, 8'h33, 8'ha5};
    send_packet();
    wait_for_records();

    // random packets; two long ones probe the 255-byte limit and the
    // saturating byte position
    while (sent_bytes < BYTE_TARGET) begin
      case (pkt_count)
        2: build_long_packet(255);
        5: build_long_packet(513);
        default: build_random_packet();
      endcase
      sent_bytes += pkt.size();
      if (pkt.size() > int'(nip_pkg::POS_LONG) - 1) long_pkts++;
      send_packet();
      pkt_count++;
      if (pkt_count % 4 == 0) wait_for_records();
    end
    in_bus.valid <= 1'b0;

    while (board.pending_records.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d packets, %0d payload bytes (%0d of 255 bytes or more), %0d records",
             board.packets, board.bytes_in, long_pkts, board.checked);
    $display("status flags set: packet %0d, mode parameters %0d, activation %0d",
             board.pkt_ok_count, board.mode_ok_count, board.act_ok_count);
    if (board.errors == 0 && board.pending_records.size() == 0) begin
      $display("nci_intf_activated_ntf_parser verification clean");
    end else begin
      $display("%0d errors, %0d records still expected", board.errors,
               board.pending_records.size());
      $display("nci_intf_activated_ntf_parser verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/nip_pkg.sv
rtl/nip_chan_if.sv
rtl/nip_front.sv
rtl/nip_queue.sv
rtl/nip_back.sv
rtl/nci_intf_activated_ntf_parser.sv
bench/nip_tb_pkg.sv
bench/tb_nci_intf_activated_ntf_parser.sv
